// ----- design/ultrasonic_parking_range_guide_unit_macros.svh -----
// Assertion macros for the ultrasonic parking range guide unit.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef ULTRASONIC_PARKING_RANGE_GUIDE_UNIT_MACROS_SVH
`define ULTRASONIC_PARKING_RANGE_GUIDE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPR_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/upr_pkg.sv -----
// Shared types, widths and constants of the ultrasonic parking range guide unit.
// No dependencies; every design module refers to it by scoped names.
package upr_pkg;

    // Sampling counts of the echo averager and the teach sequence.
    localparam int ECHO_SAMPLES  = 4;
    localparam int TEACH_SAMPLES = 4;
    localparam int PRESS_REPORTS = 2;
    localparam int HOLD_REPORTS  = 6;

    localparam int TS_W        = 32;
    localparam int DIST_W      = 16;
    localparam int MARGIN_W    = 12;
    localparam int ECHO_CNT_W  = $clog2(ECHO_SAMPLES + 1);
    localparam int ECHO_SUM_W  = TS_W + $clog2(ECHO_SAMPLES);
    localparam int TEACH_SUM_W = DIST_W + $clog2(TEACH_SAMPLES);
    localparam int TCNT_MAX    = (PRESS_REPORTS > HOLD_REPORTS) ?
                                 ((PRESS_REPORTS > TEACH_SAMPLES) ? PRESS_REPORTS : TEACH_SAMPLES) :
                                 ((HOLD_REPORTS > TEACH_SAMPLES) ? HOLD_REPORTS : TEACH_SAMPLES);
    localparam int TCNT_W      = $clog2(TCNT_MAX + 1);

    localparam logic [ECHO_CNT_W-1:0]  ECHO_CNT_FULL = ECHO_CNT_W'(ECHO_SAMPLES);
    localparam logic [ECHO_SUM_W-1:0]  ECHO_DIV      = ECHO_SUM_W'(ECHO_SAMPLES);
    localparam logic [TEACH_SUM_W-1:0] TEACH_DIV     = TEACH_SUM_W'(TEACH_SAMPLES);
    localparam logic [TCNT_W-1:0]      PRESS_CNT     = TCNT_W'(PRESS_REPORTS);
    localparam logic [TCNT_W-1:0]      HOLD_CNT      = TCNT_W'(HOLD_REPORTS);
    localparam logic [TCNT_W-1:0]      TEACH_CNT     = TCNT_W'(TEACH_SAMPLES);

    // Distance scaling: d = (diff * 100) / 1184, with 1184 = 32 * 37.
    // The divide by 37 is a reciprocal multiply, exact for 22-bit inputs.
    localparam int PROD_W      = TS_W + 7;
    localparam int QIN_LO      = 5;
    localparam int QIN_W       = 22;
    localparam int RECIP_W     = 23;
    localparam int RPROD_W     = QIN_W + RECIP_W;
    localparam int RECIP_SHIFT = 28;
    localparam logic [PROD_W-1:0]  SCALE     = PROD_W'(100);
    localparam logic [PROD_W-1:0]  SAT_LIMIT = PROD_W'(65536 * 1184);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(7255013);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVED_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MARGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_OFFSET    = 2'd2;

    localparam logic [DIST_W-1:0]   SAVED_RESET    = 16'd1200;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 12'd100;
    localparam logic [DIST_W-1:0]   OFFSET_RESET   = 16'd4000;
    localparam logic [DIST_W-1:0]   MAX_SAVED      = 16'd24000;
    localparam logic [DIST_W-1:0]   DEFAULT_TARGET = 16'd1200;

    // Request kinds on the input channel.
    localparam logic FUNC_TRIGGER = 1'b0;
    localparam logic FUNC_ECHO    = 1'b1;

    // Zone codes.
    localparam logic [1:0] ZONE_CLOSE  = 2'd0;
    localparam logic [1:0] ZONE_WINDOW = 2'd1;
    localparam logic [1:0] ZONE_FAR    = 2'd2;
    localparam logic [1:0] ZONE_TEACH  = 2'd3;

    // Teach sequence states.
    localparam logic [2:0] TEACH_IDLE     = 3'd0;
    localparam logic [2:0] TEACH_PRESSED  = 3'd1;
    localparam logic [2:0] TEACH_SAMPLING = 3'd2;
    localparam logic [2:0] TEACH_PROGRAM  = 3'd3;
    localparam logic [2:0] TEACH_DONE     = 3'd4;

    // Bit positions in the LED level vector.
    localparam int LED_BLUE   = 0;
    localparam int LED_GREEN  = 1;
    localparam int LED_YELLOW = 2;

    typedef struct packed {
        logic              valid;
        logic              button;
        logic [DIST_W-1:0] distance;
    } t_report;

    typedef struct packed {
        logic [DIST_W-1:0]   saved_distance;
        logic [MARGIN_W-1:0] window_margin;
    } t_guide_cfg;

endpackage

// ----- design/upr_echo_acc.sv -----
// Echo timer front end: latches the trigger time and sums echo times.
// Depends on upr_pkg. Flags the echo that closes a sample group as a report.
module upr_echo_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_func,
    input  logic [upr_pkg::TS_W-1:0]      i_timestamp,
    output logic                          o_report,
    output logic [upr_pkg::ECHO_SUM_W-1:0] o_sum
);

    logic [upr_pkg::TS_W-1:0]       r_start;
    logic [upr_pkg::ECHO_CNT_W-1:0] r_count;
    logic [upr_pkg::ECHO_SUM_W-1:0] r_sum;
    logic                           w_late;
    logic                           w_full;
    logic [upr_pkg::TS_W-1:0]       w_delta;

    // A wrapped counter loses one tick, as the firmware computes it.
    assign w_late  = r_start > i_timestamp;
    assign w_delta = i_timestamp - r_start - upr_pkg::TS_W'(w_late);
    assign w_full  = r_count >= upr_pkg::ECHO_CNT_FULL;

    assign o_report = i_accept && (i_func == upr_pkg::FUNC_ECHO) && w_full;
    assign o_sum    = r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_accept) begin
            if (i_func == upr_pkg::FUNC_TRIGGER) begin
                r_start <= i_timestamp;
            end else if (!w_full) begin
                r_sum   <= r_sum + upr_pkg::ECHO_SUM_W'(w_delta);
                r_count <= r_count + upr_pkg::ECHO_CNT_W'(1);
            end else begin
                r_sum   <= '0;
                r_count <= '0;
            end
        end
    end

endmodule

// ----- design/upr_dist_pipe.sv -----
// Four-stage distance pipeline: average, offset, scale by 100, divide by 1184.
// Depends on upr_pkg. Stages advance independently so bubbles collapse.
module upr_dist_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [upr_pkg::ECHO_SUM_W-1:0] i_sum,
    input  logic                           i_button,
    input  logic [upr_pkg::DIST_W-1:0]     i_offset,
    input  logic                           i_free,
    output logic                           o_ready,
    output upr_pkg::t_report               o_report
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_free1, w_free2, w_free3, w_free4;

    logic [upr_pkg::ECHO_SUM_W-1:0] r_s1_sum;
    logic                           r_s1_button;
    logic [upr_pkg::TS_W-1:0]       r_s2_diff;
    logic                           r_s2_button;
    logic [upr_pkg::PROD_W-1:0]     r_s3_prod;
    logic                           r_s3_button;
    logic [upr_pkg::RPROD_W-1:0]    r_s4_rprod;
    logic                           r_s4_sat;
    logic                           r_s4_button;

    logic [upr_pkg::TS_W-1:0]    w_avg;
    logic [upr_pkg::TS_W-1:0]    w_offset;
    logic [upr_pkg::TS_W-1:0]    w_diff;
    logic [upr_pkg::PROD_W-1:0]  w_prod;
    logic [upr_pkg::RPROD_W-1:0] w_rprod;
    logic                        w_sat;

    always_comb begin
        w_free4 = !r_v4 || i_free;
        w_free3 = !r_v3 || w_free4;
        w_free2 = !r_v2 || w_free3;
        w_free1 = !r_v1 || w_free2;
    end

    assign o_ready = w_free1;

    assign w_avg    = upr_pkg::TS_W'(r_s1_sum / upr_pkg::ECHO_DIV);
    assign w_offset = upr_pkg::TS_W'(i_offset);
    assign w_diff   = (w_avg >= w_offset) ? (w_avg - w_offset) : '0;
    assign w_prod   = upr_pkg::PROD_W'(r_s2_diff) * upr_pkg::SCALE;
    // Past the limit the quotient no longer fits 16 bits and saturates.
    assign w_sat    = r_s3_prod >= upr_pkg::SAT_LIMIT;
    assign w_rprod  = upr_pkg::RPROD_W'(r_s3_prod[upr_pkg::QIN_LO +: upr_pkg::QIN_W])
                    * upr_pkg::RPROD_W'(upr_pkg::RECIP);

    always_comb begin
        o_report.valid    = r_v4;
        o_report.button   = r_s4_button;
        o_report.distance = r_s4_sat ? '1 : r_s4_rprod[upr_pkg::RECIP_SHIFT +: upr_pkg::DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_free1) r_v1 <= i_load;
            if (w_free2) r_v2 <= r_v1;
            if (w_free3) r_v3 <= r_v2;
            if (w_free4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free1) begin
            r_s1_sum    <= i_sum;
            r_s1_button <= i_button;
        end
        if (w_free2) begin
            r_s2_diff   <= w_diff;
            r_s2_button <= r_s1_button;
        end
        if (w_free3) begin
            r_s3_prod   <= w_prod;
            r_s3_button <= r_s2_button;
        end
        if (w_free4) begin
            r_s4_rprod  <= w_rprod;
            r_s4_sat    <= w_sat;
            r_s4_button <= r_s3_button;
        end
    end

endmodule

// ----- design/upr_guide.sv -----
// Teach sequencer, window classifier, indicator levels and result register.
// Depends on upr_pkg and the assertion macros header.
`include "ultrasonic_parking_range_guide_unit_macros.svh"

module upr_guide (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  upr_pkg::t_report             i_report,
    input  upr_pkg::t_guide_cfg          i_cfg,
    input  logic                         i_ready,
    output logic                         o_free,
    output logic                         o_valid,
    output logic [upr_pkg::DIST_W-1:0]   o_distance,
    output logic [1:0]                   o_zone,
    output logic                         o_blue_led,
    output logic                         o_green_led,
    output logic                         o_yellow_led,
    output logic                         o_buzzer,
    output logic [2:0]                   o_teach_phase,
    output logic                         o_store_request,
    output logic [upr_pkg::DIST_W-1:0]   o_store_value
);

    logic [upr_pkg::DIST_W-1:0]      r_target, n_target;
    logic                            r_taught, n_taught;
    logic [2:0]                      r_teach_state, n_teach_state;
    logic [upr_pkg::TCNT_W-1:0]      r_teach_count, n_teach_count;
    logic [upr_pkg::TEACH_SUM_W-1:0] r_teach_sum, n_teach_sum;
    logic [2:0]                      r_leds, n_leds;
    logic                            r_buzzer, n_buzzer;
    logic                            r_out_valid, n_out_valid;
    logic [upr_pkg::DIST_W-1:0]      r_out_distance, n_out_distance;
    logic [1:0]                      r_out_zone, n_out_zone;
    logic                            r_out_req, n_out_req;

    logic                        w_take;
    logic [upr_pkg::DIST_W-1:0]  w_dist;
    logic [upr_pkg::DIST_W-1:0]  w_target;
    logic [upr_pkg::DIST_W-1:0]  w_margin;
    logic [upr_pkg::DIST_W-1:0]  w_lo;
    logic [upr_pkg::DIST_W:0]    w_hi;

    assign o_free = !r_out_valid || i_ready;
    assign w_take = i_report.valid && o_free;
    assign w_dist = i_report.distance;

    // Untaught, a saved distance past the sensor range falls back to the default.
    always_comb begin
        if (r_taught) begin
            w_target = r_target;
        end else if (i_cfg.saved_distance > upr_pkg::MAX_SAVED) begin
            w_target = upr_pkg::DEFAULT_TARGET;
        end else begin
            w_target = i_cfg.saved_distance;
        end
        w_margin = upr_pkg::DIST_W'(i_cfg.window_margin);
        w_lo     = (w_target > w_margin) ? (w_target - w_margin) : '0;
        w_hi     = {1'b0, w_target} + {1'b0, w_margin};
    end

    always_comb begin
        n_target       = r_target;
        n_taught       = r_taught;
        n_teach_state  = r_teach_state;
        n_teach_count  = r_teach_count;
        n_teach_sum    = r_teach_sum;
        n_leds         = r_leds;
        n_buzzer       = r_buzzer;
        n_out_valid    = o_free ? i_report.valid : r_out_valid;
        n_out_distance = r_out_distance;
        n_out_zone     = r_out_zone;
        n_out_req      = r_out_req;

        if (w_take) begin
            n_out_distance = w_dist;
            n_out_req      = 1'b0;
            if (i_report.button) begin
                n_out_zone = upr_pkg::ZONE_TEACH;
                case (r_teach_state)
                    upr_pkg::TEACH_IDLE: begin
                        if (r_teach_count < upr_pkg::PRESS_CNT) begin
                            n_teach_count = r_teach_count + upr_pkg::TCNT_W'(1);
                        end else begin
                            n_teach_count             = '0;
                            n_teach_state             = upr_pkg::TEACH_PRESSED;
                            n_leds[upr_pkg::LED_BLUE]  = 1'b0;
                            n_leds[upr_pkg::LED_GREEN] = 1'b0;
                            n_teach_sum               = '0;
                        end
                    end
                    upr_pkg::TEACH_PRESSED: begin
                        n_leds[upr_pkg::LED_YELLOW] = !r_leds[upr_pkg::LED_YELLOW];
                        if (r_teach_count < upr_pkg::HOLD_CNT) begin
                            n_teach_count = r_teach_count + upr_pkg::TCNT_W'(1);
                        end else begin
                            n_teach_count               = '0;
                            n_teach_state               = upr_pkg::TEACH_SAMPLING;
                            n_leds[upr_pkg::LED_YELLOW] = 1'b0;
                        end
                    end
                    upr_pkg::TEACH_SAMPLING: begin
                        n_leds[upr_pkg::LED_BLUE]  = !r_leds[upr_pkg::LED_BLUE];
                        n_leds[upr_pkg::LED_GREEN] = !r_leds[upr_pkg::LED_GREEN];
                        if (r_teach_count < upr_pkg::TEACH_CNT) begin
                            n_teach_count = r_teach_count + upr_pkg::TCNT_W'(1);
                            n_teach_sum   = r_teach_sum + upr_pkg::TEACH_SUM_W'(w_dist);
                        end else begin
                            n_teach_count = '0;
                            n_teach_sum   = r_teach_sum / upr_pkg::TEACH_DIV;
                            n_teach_state = upr_pkg::TEACH_PROGRAM;
                        end
                    end
                    upr_pkg::TEACH_PROGRAM: begin
                        n_teach_state = upr_pkg::TEACH_DONE;
                    end
                    default: begin
                        n_teach_state = r_teach_state;
                    end
                endcase
                // Once the sequence is done, every held report re-saves the target.
                if (n_teach_state > upr_pkg::TEACH_PROGRAM) begin
                    n_target  = n_teach_sum[upr_pkg::DIST_W-1:0];
                    n_taught  = 1'b1;
                    n_out_req = 1'b1;
                end
            end else begin
                // Press reports counted while idle survive a release.
                if (r_teach_state != upr_pkg::TEACH_IDLE) begin
                    n_teach_state = upr_pkg::TEACH_IDLE;
                    n_teach_count = '0;
                end
                if (w_dist < w_lo) begin
                    n_leds[upr_pkg::LED_GREEN] = 1'b0;
                    n_leds[upr_pkg::LED_BLUE]  = 1'b1;
                    n_buzzer                   = 1'b1;
                    n_out_zone                 = upr_pkg::ZONE_CLOSE;
                end else if ({1'b0, w_dist} < w_hi) begin
                    n_leds[upr_pkg::LED_GREEN] = 1'b1;
                    n_leds[upr_pkg::LED_BLUE]  = 1'b1;
                    n_buzzer                   = !r_buzzer;
                    n_out_zone                 = upr_pkg::ZONE_WINDOW;
                end else begin
                    n_leds[upr_pkg::LED_GREEN] = 1'b1;
                    n_leds[upr_pkg::LED_BLUE]  = 1'b0;
                    n_buzzer                   = 1'b0;
                    n_out_zone                 = upr_pkg::ZONE_FAR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target      <= '0;
            r_taught      <= 1'b0;
            r_teach_state <= upr_pkg::TEACH_IDLE;
            r_teach_count <= '0;
            r_teach_sum   <= '0;
            r_leds        <= 3'b011;
            r_buzzer      <= 1'b1;
            r_out_valid   <= 1'b0;
            r_out_req     <= 1'b0;
        end else begin
            r_target      <= n_target;
            r_taught      <= n_taught;
            r_teach_state <= n_teach_state;
            r_teach_count <= n_teach_count;
            r_teach_sum   <= n_teach_sum;
            r_leds        <= n_leds;
            r_buzzer      <= n_buzzer;
            r_out_valid   <= n_out_valid;
            r_out_req     <= n_out_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_distance <= n_out_distance;
        r_out_zone     <= n_out_zone;
    end

    // Indicator levels and the teach phase change only when a new result is
    // loaded, so they can drive the result ports straight from the state.
    assign o_valid         = r_out_valid;
    assign o_distance      = r_out_distance;
    assign o_zone          = r_out_zone;
    assign o_blue_led      = r_leds[upr_pkg::LED_BLUE];
    assign o_green_led     = r_leds[upr_pkg::LED_GREEN];
    assign o_yellow_led    = r_leds[upr_pkg::LED_YELLOW];
    assign o_buzzer        = r_buzzer;
    assign o_teach_phase   = r_teach_state;
    assign o_store_request = r_out_req;
    assign o_store_value   = r_out_req ? r_target : '0;

    `UPR_ASSERT_HOLDS(a_req_only_done, o_valid && o_store_request,
        o_teach_phase == upr_pkg::TEACH_DONE, "store request outside the done phase")
    `UPR_ASSERT_HOLDS(a_idle_unless_teach, o_valid && (o_zone != upr_pkg::ZONE_TEACH),
        o_teach_phase == upr_pkg::TEACH_IDLE, "teach phase left active after a release")
    `UPR_ASSERT_HOLDS(a_close_levels, o_valid && (o_zone == upr_pkg::ZONE_CLOSE),
        o_blue_led && !o_green_led && o_buzzer, "wrong indicator levels in the close zone")
    `UPR_ASSERT_NEXT(a_release_result, w_take && !i_report.button,
        o_valid && (o_zone != upr_pkg::ZONE_TEACH), "released report gave no range result")

endmodule

// ----- design/ultrasonic_parking_range_guide_unit.sv -----
// Top level of the ultrasonic parking range guide unit.
// Depends on upr_pkg, upr_echo_acc, upr_dist_pipe and upr_guide.
//
// Usage:
//   Input channel (i_valid / o_ready): a request with i_func low latches
//   i_timestamp as the trigger time; one with i_func high is an echo edge.
//   Four echoes are summed; the fifth echo yields one result on the output
//   channel (o_valid / i_ready). Triggers and summed echoes give no result.
//   Result path: the edge that accepts the fifth echo loads its sum into the
//   front register, then three arithmetic stages, then the result register.
//   Throughput: one request per cycle while o_ready is high; each stage of the
//   chain up to the reciprocal multiply for the divide by 1184 is registered.
//   Stall: while a result waits, the four stages keep taking reports, and
//   o_ready drops only when all of them hold one.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 saved distance, 1 window margin, 2 echo offset); other indexes are
//   ignored. Write only while no request is in flight.
//   Reset: synchronous, active low; clears sums, the teach sequence and
//   the pipeline, sets blue, green and the buzzer on, and loads the
//   register defaults 1200, 100 and 4000.
module ultrasonic_parking_range_guide_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [upr_pkg::TS_W-1:0]        i_timestamp,
    input  logic                            i_button,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [upr_pkg::DIST_W-1:0]      o_distance,
    output logic [1:0]                      o_zone,
    output logic                            o_blue_led,
    output logic                            o_green_led,
    output logic                            o_yellow_led,
    output logic                            o_buzzer,
    output logic [2:0]                      o_teach_phase,
    output logic                            o_store_request,
    output logic [upr_pkg::DIST_W-1:0]      o_store_value,
    input  logic                            i_cfg_we,
    input  logic [upr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [upr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [upr_pkg::DIST_W-1:0]   r_saved_distance;
    logic [upr_pkg::MARGIN_W-1:0] r_window_margin;
    logic [upr_pkg::DIST_W-1:0]   r_echo_offset;

    logic                           w_accept;
    logic                           w_report;
    logic [upr_pkg::ECHO_SUM_W-1:0] w_sum;
    logic                           w_free;
    upr_pkg::t_report               w_dist_report;
    upr_pkg::t_guide_cfg            w_guide_cfg;

    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved_distance <= upr_pkg::SAVED_RESET;
            r_window_margin  <= upr_pkg::MARGIN_RESET;
            r_echo_offset    <= upr_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                upr_pkg::CFG_SAVED_DISTANCE: r_saved_distance <= i_cfg_data;
                upr_pkg::CFG_WINDOW_MARGIN: begin
                    r_window_margin <= i_cfg_data[upr_pkg::MARGIN_W-1:0];
                end
                upr_pkg::CFG_ECHO_OFFSET: r_echo_offset <= i_cfg_data;
                default: r_echo_offset <= r_echo_offset;
            endcase
        end
    end

    always_comb begin
        w_guide_cfg.saved_distance = r_saved_distance;
        w_guide_cfg.window_margin  = r_window_margin;
    end

    upr_echo_acc u_echo_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_func      (i_func),
        .i_timestamp (i_timestamp),
        .o_report    (w_report),
        .o_sum       (w_sum)
    );

    upr_dist_pipe u_dist_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_report),
        .i_sum    (w_sum),
        .i_button (i_button),
        .i_offset (r_echo_offset),
        .i_free   (w_free),
        .o_ready  (o_ready),
        .o_report (w_dist_report)
    );

    upr_guide u_guide (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_report        (w_dist_report),
        .i_cfg           (w_guide_cfg),
        .i_ready         (i_ready),
        .o_free          (w_free),
        .o_valid         (o_valid),
        .o_distance      (o_distance),
        .o_zone          (o_zone),
        .o_blue_led      (o_blue_led),
        .o_green_led     (o_green_led),
        .o_yellow_led    (o_yellow_led),
        .o_buzzer        (o_buzzer),
        .o_teach_phase   (o_teach_phase),
        .o_store_request (o_store_request),
        .o_store_value   (o_store_value)
    );

endmodule
